>>> rtl/core/pti_pkg.sv
// ----------------------------------------------------------------------------
// pti_pkg
// shared types, widths and codes of the periodic trilinear interpolator
// ----------------------------------------------------------------------------
package pti_pkg;

  localparam int SIZE_W = 13;   // grid size register width
  localparam int COMP_W = 3;    // components register width
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 144;
  localparam int OUT_DATA_W = 40;

  localparam int STORE_WORDS_DEF = 65536;
  localparam int MAX_COMPONENTS_DEF = 4;
  localparam int MAX_DIM_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 2'd3;

  localparam logic CMD_WRITE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LIM1, ST_LIM2, ST_LIM3, ST_WRITE, ST_MOD, ST_MODFIX,
    ST_ADR_A, ST_ADR_B, ST_ADR_C, ST_RD, ST_ML, ST_MH, ST_AC, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LIM1, OP_LIM2, OP_LIM3, OP_WRITE, OP_MOD, OP_MODFIX,
    OP_ADR_A, OP_ADR_B, OP_ADR_C, OP_RD, OP_MUL_LO, OP_MUL_HI, OP_ACC, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [2:0]        corner;
    logic [COMP_W-1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic comp_last;
    logic out_busy;
  } status_t;

endpackage

>>> rtl/core/pti_ctrl.sv
// ----------------------------------------------------------------------------
// pti_ctrl
// sequencer for sample writes and trilinear queries
// ----------------------------------------------------------------------------
module pti_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_cmd_i,
  output logic             req_ready_o,
  input  pti_pkg::status_t status_i,
  output pti_pkg::cmd_t    cmd_o
);
  import pti_pkg::*;

  state_e            state_q, state_d;
  logic [3:0]        bit_q, bit_d;
  logic [2:0]        corner_q, corner_d;
  logic [COMP_W-1:0] comp_q, comp_d;
  logic              accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept = req_valid_i && req_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = (req_cmd_i == CMD_WRITE) ? ST_LIM1 : ST_MOD;
      ST_LIM1:   state_d = ST_LIM2;
      ST_LIM2:   state_d = ST_LIM3;
      ST_LIM3:   state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_IDLE;
      ST_MOD:    if (bit_q == 4'd15) state_d = ST_MODFIX;
      ST_MODFIX: state_d = ST_ADR_A;
      ST_ADR_A:  state_d = ST_ADR_B;
      ST_ADR_B:  state_d = ST_ADR_C;
      ST_ADR_C:  state_d = (corner_q == 3'd7) ? ST_RD : ST_ADR_A;
      ST_RD:     state_d = ST_ML;
      ST_ML:     state_d = ST_MH;
      ST_MH:     state_d = ST_AC;
      ST_AC:     state_d = (corner_q == 3'd7) ? ST_FIN : ST_RD;
      ST_FIN:    if (!status_i.out_busy) state_d = status_i.comp_last ? ST_IDLE : ST_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    bit_d = bit_q;
    corner_d = corner_q;
    comp_d = comp_q;
    unique case (state_q)
      ST_IDLE: begin
        bit_d = '0;
        corner_d = '0;
        comp_d = '0;
      end
      ST_MOD:  bit_d = bit_q + 4'd1;
      ST_ADR_C, ST_AC: corner_d = corner_q + 3'd1;
      ST_FIN:  if (!status_i.out_busy) comp_d = comp_q + COMP_W'(1);
      default: ;
    endcase
  end

  // datapath command
  always_comb begin
    cmd_o.corner = corner_q;
    cmd_o.comp = comp_q;
    unique case (state_q)
      ST_IDLE:   cmd_o.op = accept ? OP_LOAD : OP_NONE;
      ST_LIM1:   cmd_o.op = OP_LIM1;
      ST_LIM2:   cmd_o.op = OP_LIM2;
      ST_LIM3:   cmd_o.op = OP_LIM3;
      ST_WRITE:  cmd_o.op = OP_WRITE;
      ST_MOD:    cmd_o.op = OP_MOD;
      ST_MODFIX: cmd_o.op = OP_MODFIX;
      ST_ADR_A:  cmd_o.op = OP_ADR_A;
      ST_ADR_B:  cmd_o.op = OP_ADR_B;
      ST_ADR_C:  cmd_o.op = OP_ADR_C;
      ST_RD:     cmd_o.op = OP_RD;
      ST_ML:     cmd_o.op = OP_MUL_LO;
      ST_MH:     cmd_o.op = OP_MUL_HI;
      ST_AC:     cmd_o.op = OP_ACC;
      ST_FIN:    cmd_o.op = status_i.out_busy ? OP_NONE : OP_EMIT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bit_q <= '0;
      corner_q <= '0;
      comp_q <= '0;
    end else begin
      state_q <= state_d;
      bit_q <= bit_d;
      corner_q <= corner_d;
      comp_q <= comp_d;
    end
  end

  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MOD && bit_q == 4'd15 |=> state_q == ST_MODFIX)
    else $error("modulo did not finish after sixteen steps");

  a_corner_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_AC && corner_q == 3'd7 |=> state_q == ST_FIN && corner_q == 3'd0)
    else $error("corner loop did not close");

  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && !status_i.out_busy && status_i.comp_last |=> state_q == ST_IDLE)
    else $error("query did not return to idle after last component");

endmodule

>>> rtl/core/pti_datapath.sv
// ----------------------------------------------------------------------------
// pti_datapath
// config registers, sample store, wrap, address and weighted-sum arithmetic
// ----------------------------------------------------------------------------
module pti_datapath #(
  parameter int STORE_WORDS = pti_pkg::STORE_WORDS_DEF,
  parameter int MAX_COMPONENTS = pti_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_DIM = pti_pkg::MAX_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [pti_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pti_pkg::SIZE_W-1:0]         cfg_data_i,
  input  logic [pti_pkg::IN_DATA_W-1:0]      req_data_i,
  input  pti_pkg::cmd_t                      cmd_i,
  output pti_pkg::status_t                   status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pti_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                               out_last_o
);
  import pti_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int BASE_W = 45;
  localparam int ACC_W = 81;
  localparam logic signed [ACC_W-1:0] HALF = {34'b0, 1'b1, 46'b0} <<< 1;

  // configuration
  logic [SIZE_W-1:0] size_q [3];
  logic [COMP_W-1:0] comp_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0] <= SIZE_W'(16);
      size_q[1] <= SIZE_W'(16);
      size_q[2] <= SIZE_W'(16);
      comp_cfg_q <= COMP_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SIZE_X:     size_q[0] <= cfg_data_i;
        CFG_SIZE_Y:     size_q[1] <= cfg_data_i;
        CFG_SIZE_Z:     size_q[2] <= cfg_data_i;
        CFG_COMPONENTS: comp_cfg_q <= cfg_data_i[COMP_W-1:0];
      endcase
    end
  end

  logic [SIZE_W-1:0] n [3];
  logic [COMP_W-1:0] nc;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (size_q[a] == '0) n[a] = SIZE_W'(1);
      else if (32'(size_q[a]) > 32'(MAX_DIM)) n[a] = SIZE_W'(MAX_DIM);
      else n[a] = size_q[a];
    end
    if (comp_cfg_q == '0) nc = COMP_W'(1);
    else if (32'(comp_cfg_q) > 32'(MAX_COMPONENTS)) nc = COMP_W'(MAX_COMPONENTS);
    else nc = comp_cfg_q;
  end

  // request capture and per-axis wrap
  logic [15:0]        idx_q;
  logic signed [31:0] wval_q;
  logic [15:0]        mag_q [3];
  logic               neg_q [3];
  logic [15:0]        frac_q [3];
  logic [SIZE_W-1:0]  rem_q [3];
  logic [SIZE_W-1:0]  lo_q [3];
  logic [SIZE_W-1:0]  hi_q [3];

  logic [25:0] lim1_q;
  logic [38:0] lim2_q;
  logic [41:0] lim3_q;

  logic [25:0]        t1_q;
  logic [39:0]        t2_q;
  logic [33:0]        wxy_q;
  logic [48:0]        wc_q;
  logic [BASE_W-1:0]  base_q [8];
  logic [48:0]        w_q [8];

  logic                      inr_q;
  logic [31:0]               rdata_q;
  logic signed [ACC_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [31:0]               mem [STORE_WORDS];

  logic [SIZE_W-1:0]  xa, ya, za;
  logic [16:0]        wx, wy, wz;
  logic [BASE_W-1:0]  rd_addr;
  logic [48:0]        wsel;
  logic signed [31:0] samp;
  logic signed [64:0] plo;
  logic signed [49:0] phi;
  logic signed [ACC_W-1:0] rsum;
  logic               wr_ok;

  always_comb begin
    xa = cmd_i.corner[0] ? hi_q[0] : lo_q[0];
    ya = cmd_i.corner[1] ? hi_q[1] : lo_q[1];
    za = cmd_i.corner[2] ? hi_q[2] : lo_q[2];
    wx = cmd_i.corner[0] ? {1'b0, frac_q[0]} : 17'h10000 - {1'b0, frac_q[0]};
    wy = cmd_i.corner[1] ? {1'b0, frac_q[1]} : 17'h10000 - {1'b0, frac_q[1]};
    wz = cmd_i.corner[2] ? {1'b0, frac_q[2]} : 17'h10000 - {1'b0, frac_q[2]};
    rd_addr = base_q[cmd_i.corner] + BASE_W'(cmd_i.comp);
    wsel = w_q[cmd_i.corner];
    samp = inr_q ? $signed(rdata_q) : 32'sd0;
    plo = samp * $signed({1'b0, wsel[31:0]});
    phi = samp * $signed({1'b0, wsel[48:32]});
    rsum = acc_q + HALF;
    wr_ok = (42'(idx_q) < lim3_q) && (32'(idx_q) < 32'(STORE_WORDS));
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        idx_q <= req_data_i[15:0];
        wval_q <= $signed(req_data_i[47:16]);
        for (int a = 0; a < 3; a++) begin
          frac_q[a] <= req_data_i[48 + 32*a +: 16];
          neg_q[a] <= req_data_i[79 + 32*a];
          mag_q[a] <= req_data_i[79 + 32*a] ? 16'(~req_data_i[64 + 32*a +: 16] + 16'd1)
                                            : req_data_i[64 + 32*a +: 16];
          rem_q[a] <= '0;
        end
      end
      OP_LIM1: lim1_q <= 26'(n[0]) * 26'(n[1]);
      OP_LIM2: lim2_q <= 39'(lim1_q) * 39'(n[2]);
      OP_LIM3: lim3_q <= 42'(lim2_q) * 42'(nc);
      OP_MOD: begin
        // one restoring step per axis
        for (int a = 0; a < 3; a++) begin
          if ({rem_q[a], mag_q[a][15]} >= {1'b0, n[a]})
            rem_q[a] <= SIZE_W'({rem_q[a], mag_q[a][15]} - {1'b0, n[a]});
          else
            rem_q[a] <= SIZE_W'({rem_q[a], mag_q[a][15]});
          mag_q[a] <= {mag_q[a][14:0], 1'b0};
        end
      end
      OP_MODFIX: begin
        for (int a = 0; a < 3; a++) begin
          logic [SIZE_W-1:0] r;
          r = (neg_q[a] && rem_q[a] != '0) ? n[a] - rem_q[a] : rem_q[a];
          lo_q[a] <= r;
          hi_q[a] <= ({1'b0, r} + 14'd1 == {1'b0, n[a]}) ? '0 : r + SIZE_W'(1);
        end
      end
      OP_ADR_A: begin
        t1_q <= 26'(n[1]) * 26'(za);
        wxy_q <= 34'(wx) * 34'(wy);
      end
      OP_ADR_B: begin
        t2_q <= 40'(n[0]) * (40'(ya) + 40'(t1_q));
        wc_q <= 49'(51'(wxy_q) * 51'(wz));
      end
      OP_ADR_C: begin
        base_q[cmd_i.corner] <= BASE_W'(44'(nc) * (44'(xa) + 44'(t2_q)));
        w_q[cmd_i.corner] <= wc_q;
      end
      OP_RD: inr_q <= rd_addr < BASE_W'(STORE_WORDS);
      OP_MUL_LO: prod_q <= ACC_W'(plo);
      OP_MUL_HI: prod_q <= $signed({phi[48:0], 32'b0});
      default: ;
    endcase
  end

  // single-port sample store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE && wr_ok) mem[AW'(idx_q)] <= wval_q;
    else if (cmd_i.op == OP_RD) rdata_q <= mem[AW'(rd_addr)];
  end

  // accumulator and output register
  logic              out_valid_q;
  logic [31:0]       out_value_q;
  logic [1:0]        out_comp_q;
  logic              out_last_q;
  logic              comp_last;

  assign comp_last = ({1'b0, cmd_i.comp} + 4'd1) == {1'b0, nc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: acc_q <= '0;
      OP_MUL_HI, OP_ACC: acc_q <= acc_q + prod_q;
      OP_EMIT: begin
        acc_q <= '0;
        out_value_q <= rsum[79:48];
        out_comp_q <= 2'(cmd_i.comp);
        out_last_q <= comp_last;
      end
      default: ;
    endcase
  end

  assign status_o.comp_last = comp_last;
  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o = {6'b0, out_comp_q, out_value_q};
  assign out_last_o = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_EMIT |-> !(out_valid_q && !out_ready_i))
    else $error("result emitted over a waiting result");

endmodule

>>> rtl/core/periodic_trilinear_interpolator.sv
// write request: store updated in the WRITE state after the size-limit products; no result
// query: a 16-step modulo per axis, then address/weight setup for each of the
//   eight corners, then for each of nc effective components every neighbour
//   sample in turn (store read, two partial products, accumulate)
// one request at a time; a waiting result does not hold up the next request
// reset (async, active low) clears control and config; store is not cleared
// ----------------------------------------------------------------------------
// periodic_trilinear_interpolator
// trilinear blend over a periodic 3-d sample grid held in a single-port store
// ----------------------------------------------------------------------------
module periodic_trilinear_interpolator #(
  parameter int STORE_WORDS = pti_pkg::STORE_WORDS_DEF,
  parameter int MAX_COMPONENTS = pti_pkg::MAX_COMPONENTS_DEF,
  parameter int MAX_DIM = pti_pkg::MAX_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // word_index[15:0], word_value[47:16], coord_x[79:48], coord_y[111:80],
  // coord_z[143:112]
  input  logic [pti_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // cmd[0]
  input  logic                               s_axis_tuser,
  // result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // value[31:0], component[33:32], zero padding[39:34]
  output logic [pti_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pti_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pti_pkg::SIZE_W-1:0]         cfg_data_i
);
  import pti_pkg::*;

  cmd_t    cmd;
  status_t status;

  // config registers can always take a write
  assign cfg_ready_o = 1'b1;

  // sequencer: one request in flight
  pti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_cmd_i   (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, sample store and output register
  pti_datapath #(
    .STORE_WORDS    (STORE_WORDS),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_DIM        (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_data_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> tb/tb_periodic_trilinear_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_trilinear_interpolator
// self-checking bench: sample writes and point queries over periodic grids of
// many shapes, each result checked against a fixed-point trilinear predictor
// ----------------------------------------------------------------------------
module tb_periodic_trilinear_interpolator;
  import pti_pkg::*;

  localparam logic CMD_QUERY = 1'b1;
  localparam int   LIMIT_CYCLES = 2000000;
  localparam int   SETTLE_CYCLES = 220;  // longest query plus a write in flight

  typedef struct {
    logic [31:0] value;
    logic [1:0]  comp;
    logic        last;
  } blend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0] cfg_data_i = '0;

  // shadow of the block: sample store, which words hold data, registers
  logic [31:0] sample_mem [0:65535];
  bit          word_written [0:65535];
  logic [SIZE_W-1:0] grid_x = SIZE_W'(16), grid_y = SIZE_W'(16), grid_z = SIZE_W'(16);
  logic [COMP_W-1:0] comp_reg = COMP_W'(1);

  blend_t blend_q[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_cycles = 0;          // long receiver hold-off, counted down below
  int cycle_cnt = 0, mismatches = 0;
  int n_writes = 0, n_queries = 0, n_results = 0;

  periodic_trilinear_interpolator uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side back-pressure: a long hold-off first, otherwise random stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // result checker against the oldest expected blend
  always @(posedge clk_i) begin
    blend_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (blend_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        exp_b = blend_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_b.value || m_axis_tdata[33:32] !== exp_b.comp ||
            m_axis_tlast !== exp_b.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %h comp %0d last %b, got %h comp %0d last %b",
                     exp_b.value, exp_b.comp, exp_b.last, m_axis_tdata[31:0],
                     m_axis_tdata[33:32], m_axis_tlast);
        end
      end
    end
  end

  // effective register values: zero acts as one, large values clamp
  function automatic longint dim_of(logic [SIZE_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
    return r;
  endfunction

  function automatic longint comps_of();
    if (comp_reg == 0) return 1;
    if (comp_reg > MAX_COMPONENTS_DEF) return MAX_COMPONENTS_DEF;
    return comp_reg;
  endfunction

  // wrapped node (lower or upper neighbour) along one axis
  function automatic longint wrap_node(logic [31:0] c, longint n, bit upper);
    longint ip, r;
    ip = longint'($signed(c[31:16]));
    r = ip % n;
    if (r < 0) r += n;
    if (upper) r = (r + 1 == n) ? 0 : r + 1;
    return r;
  endfunction

  function automatic longint corner_addr(logic [31:0] cx, cy, cz, longint k,
                                         logic [2:0] corner);
    longint nx, ny, nz, nc;
    nx = dim_of(grid_x);
    ny = dim_of(grid_y);
    nz = dim_of(grid_z);
    nc = comps_of();
    return k + nc * (wrap_node(cx, nx, corner[0]) + nx * (wrap_node(cy, ny, corner[1])
           + ny * wrap_node(cz, nz, corner[2])));
  endfunction

  // exact weighted sum over 2^48, rounded to nearest with ties upward
  task automatic predict_blend(input logic [31:0] cx, cy, cz);
    longint nc, addr, w;
    logic signed [127:0] acc, sv, sw;
    blend_t b;
    nc = comps_of();
    for (longint k = 0; k < nc; k++) begin
      acc = '0;
      for (int c = 0; c < 8; c++) begin
        addr = corner_addr(cx, cy, cz, k, c[2:0]);
        sv = (addr < STORE_WORDS_DEF) ? longint'($signed(sample_mem[addr])) : 0;
        w = (c[0] ? longint'(cx[15:0]) : 65536 - longint'(cx[15:0]))
          * (c[1] ? longint'(cy[15:0]) : 65536 - longint'(cy[15:0]))
          * (c[2] ? longint'(cz[15:0]) : 65536 - longint'(cz[15:0]));
        sw = w;
        acc += sv * sw;
      end
      acc = (acc + (128'sd1 <<< 47)) >>> 48;
      b.value = acc[31:0];
      b.comp = k[1:0];
      b.last = (k + 1 == nc);
      blend_q.push_back(b);
    end
  endtask

  // one request on the input stream, sometimes with a random gap ahead of it
  task automatic send_request(input logic cmd, input logic [15:0] idx,
                              input logic [31:0] val, cx, cy, cz);
    longint lim;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tdata <= {cz, cy, cx, val, idx};
    s_axis_tuser <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_WRITE) begin
      n_writes++;
      lim = comps_of() * dim_of(grid_x) * dim_of(grid_y) * dim_of(grid_z);
      if (idx < lim) begin
        sample_mem[idx] = val;
        word_written[idx] = 1'b1;
      end
    end else begin
      n_queries++;
      predict_blend(cx, cy, cz);
    end
  endtask

  task automatic write_word(input logic [15:0] idx, input logic [31:0] val);
    send_request(CMD_WRITE, idx, val, $urandom, $urandom, $urandom);
  endtask

  // query a point after filling any neighbour word that holds no data yet
  task automatic query_point(input logic [31:0] cx, cy, cz);
    longint addr;
    for (longint k = 0; k < comps_of(); k++)
      for (int c = 0; c < 8; c++) begin
        addr = corner_addr(cx, cy, cz, k, c[2:0]);
        if (addr < STORE_WORDS_DEF && !word_written[addr])
          write_word(addr[15:0], $urandom);
      end
    send_request(CMD_QUERY, 16'($urandom), $urandom, cx, cy, cz);
  endtask

  // stop sending, wait for every result, then let a write in flight finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SIZE_X:     grid_x = val;
      CFG_SIZE_Y:     grid_y = val;
      CFG_SIZE_Z:     grid_z = val;
      CFG_COMPONENTS: comp_reg = val[COMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [SIZE_W-1:0] sx, sy, sz, input logic [SIZE_W-1:0] nc);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    write_reg(CFG_COMPONENTS, nc);
  endtask

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    if ($urandom_range(0, 3) == 0) return $urandom;
    c = {16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535))};
    return $urandom_range(0, 1) ? -c : c;
  endfunction

  // reset-default grid: extreme samples, coordinates and rounding ties
  task automatic test_default_grid();
    write_word(16'd0, 32'h7FFF_FFFF);
    write_word(16'd1, 32'h8000_0000);
    query_point(32'h0000_8000, 32'h0, 32'h0);   // halfway between extremes
    write_word(16'd2, 32'd1);
    write_word(16'd3, 32'd0);
    query_point(32'h0002_8000, 32'h0, 32'h0);   // +0.5 tie rounds up
    write_word(16'd2, 32'hFFFF_FFFF);
    query_point(32'h0002_8000, 32'h0, 32'h0);   // -0.5 tie rounds up to zero
    write_word(16'd4096, 32'h1234_5678);        // just outside the grid: ignored
    write_word(16'hFFFF, 32'h5555_AAAA);        // far outside: ignored
    query_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query_point(32'hFFFF_0001, 32'h000F_FFFF, 32'hFFF0_FFFF);  // wrap at the edge
    drain();
  endtask

  // clamped and degenerate register values
  task automatic test_register_extremes();
    set_grid(13'd0, 13'd0, 13'd0, 13'd0);       // all act as one
    query_point(32'h0003_4000, 32'hFFFE_C000, 32'h1234_5678);
    drain();
    set_grid(13'h1FFF, 13'd1, 13'd1, 13'd7);    // clamp to max size and components
    query_point(32'h0FFF_8000, 32'h0, 32'h0);   // upper x neighbour wraps to node 0
    query_point(32'h0000_0000, 32'h8000_FFFF, 32'h0);
    drain();
    set_grid(13'd4096, 13'd4096, 13'd4096, 13'd4); // far corners read beyond the store
    query_point(32'h0001_2000, 32'h0003_3000, 32'h0005_4000);
    drain();
  endtask

  // random grids and random mixes of requests
  task automatic test_random_traffic(input int n_actions);
    int pick;
    set_grid(SIZE_W'($urandom_range(0, 5)), SIZE_W'($urandom_range(0, 5)),
             SIZE_W'($urandom_range(0, 4)), SIZE_W'($urandom_range(0, 7)));
    for (int i = 0; i < n_actions; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        query_point(rand_coord(), rand_coord(), rand_coord());
      else if (pick < 85)
        write_word(16'($urandom_range(0, comps_of() * dim_of(grid_x) * dim_of(grid_y) *
                   dim_of(grid_z) - 1)), $urandom);
      else
        write_word(16'($urandom), $urandom);
    end
    drain();
  endtask

  // queries under random stalls, then a long result hold-off so the block stalls its input
  task automatic test_backpressure();
    set_grid(13'd3, 13'd2, 13'd2, 13'd2);
    for (int i = 0; i < 6; i++) query_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    hold_cycles = 3000;
    for (int i = 0; i < 6; i++) query_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 32;
    recv_stall_pct = 72;
    test_default_grid();
    test_register_extremes();
    test_random_traffic(12);
    send_idle_pct = 72;
    recv_stall_pct = 32;
    test_random_traffic(12);
    test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(12);
    $display("covered %0d sample writes and %0d queries giving %0d results,",
             n_writes, n_queries, n_results);
    $display("over clamped, single-node and random periodic grids with back-pressure");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pti_pkg.sv
rtl/core/pti_ctrl.sv
rtl/core/pti_datapath.sv
rtl/core/periodic_trilinear_interpolator.sv
tb/tb_periodic_trilinear_interpolator.sv
